// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/core/dssw_pkg.sv -----
// ----------------------------------------------------------------------------
// dssw_pkg
// Types and constants of the smoothing stencil weight pipeline.
// ----------------------------------------------------------------------------
package dssw_pkg;

	localparam int unsigned PIXEL_COUNT = 1048576;
	localparam int unsigned NLANE       = 4;   // below, above, left, right
	localparam int unsigned DIV_STEPS   = 17;  // quotient bits, weight <= 2^16
	localparam int unsigned DEN_W       = 33;
	localparam int unsigned TRIAL_W     = DEN_W + DIV_STEPS - 1;
	localparam int unsigned NSTAGE      = DIV_STEPS + 3;

	localparam logic [15:0] BETA_RST   = 16'd256;
	localparam logic [15:0] THRESH_RST = 16'd1024;
	localparam logic [DEN_W-1:0] DEN_ONE = DEN_W'(65536);
	localparam logic [DEN_W-1:0] NUMER   = DEN_W'(64'h1_0000_0000);

	typedef enum logic [0:0] {
		REG_BETA   = 1'b0,
		REG_THRESH = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [19:0]        pixel_index;
		logic [15:0]        center_depth;
		logic [15:0]        below_depth;
		logic [15:0]        above_depth;
		logic [15:0]        left_depth;
		logic [15:0]        right_depth;
		logic signed [15:0] alpha;
		logic               interior;
	} in_item_t;

	typedef struct packed {
		logic [19:0]        matrix_row;
		logic               row_written;
		logic [24:0]        diag_coeff;
		logic signed [18:0] coeff_below;
		logic signed [18:0] coeff_above;
		logic signed [18:0] coeff_left;
		logic signed [18:0] coeff_right;
		logic [23:0]        rhs_value;
	} out_item_t;

	typedef struct packed {
		logic [19:0]                  idx;
		logic                         wr;
		logic                         live;
		logic [14:0]                  alpha_c;
		logic [7:0]                   ci;
		logic [NLANE-1:0]             keep;
		logic [NLANE-1:0][15:0]       diff;
	} s1_t;

	typedef struct packed {
		logic [19:0]                  idx;
		logic                         wr;
		logic                         live;
		logic [14:0]                  alpha_c;
		logic [23:0]                  rhs;
		logic [NLANE-1:0]             keep;
		logic [NLANE-1:0][DEN_W-1:0]  den;
		logic [NLANE-1:0][DEN_W-1:0]  rem;
		logic [NLANE-1:0][DIV_STEPS-1:0] q;
	} div_t;

endpackage

// ----- rtl/core/dssw_stream_if.sv -----
// ----------------------------------------------------------------------------
// Stream interfaces
// Valid/ready channels for pixel items in and stencil rows out.
// ----------------------------------------------------------------------------
interface dssw_in_if import dssw_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dssw_out_if import dssw_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/depth_smoothing_stencil_weights.sv -----
// ----------------------------------------------------------------------------
// depth_smoothing_stencil_weights
// Edge-aware Laplacian stencil row generator for a Q8.8 depth map.
// ----------------------------------------------------------------------------
// One pixel item per clock enters and one stencil row leaves per clock while
// the output is not stalled; each item passes the input stage, the multiply
// stage, 17 divide steps and the output stage. The pipe depth comes from the
// four restoring dividers that form w = 2^32 / (65536 + beta*diff), one
// quotient bit per stage. Stages hold while the one ahead is full and stalled,
// so bubbles close up; while a finished row waits, the input fills the pipe.
// Write beta and diff_threshold only while the pipe is empty.
`include "assert_macros.svh"

module depth_smoothing_stencil_weights import dssw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	dssw_in_if.sink     pix,
	dssw_out_if.source  row,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	// Configuration registers
	logic [15:0] beta_q, thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q <= BETA_RST;
			thr_q  <= THRESH_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BETA:   beta_q <= cfg_wdata;
				REG_THRESH: thr_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Stage control: a stage advances when it is empty or the next one moves.
	logic [NSTAGE-1:0] vld, en;

	always_comb begin
		en[NSTAGE-1] = !vld[NSTAGE-1] || row.ready;
		for (int i = NSTAGE - 2; i >= 0; i--) begin
			en[i] = !vld[i] || en[i+1];
		end
	end

	assign pix.ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (en[0]) begin
				vld[0] <= pix.valid;
			end
			for (int i = 1; i < NSTAGE; i++) begin
				if (en[i]) begin
					vld[i] <= vld[i-1];
				end
			end
		end
	end

	// Stage 1: clamp alpha, truncate centre, form differences and dismissals
	s1_t         s1_d, p_s1;
	logic [15:0] nb [NLANE];
	logic [15:0] ctr;

	always_comb begin
		nb[0] = pix.data.below_depth;
		nb[1] = pix.data.above_depth;
		nb[2] = pix.data.left_depth;
		nb[3] = pix.data.right_depth;
		ctr   = {pix.data.center_depth[15:8], 8'h00};
		s1_d.idx     = pix.data.pixel_index;
		s1_d.wr      = pix.data.interior && (32'(pix.data.pixel_index) < PIXEL_COUNT);
		s1_d.live    = s1_d.wr && (pix.data.center_depth[15:8] != 8'd0);
		s1_d.alpha_c = pix.data.alpha[15] ? 15'd0 : pix.data.alpha[14:0];
		s1_d.ci      = pix.data.center_depth[15:8];
		for (int k = 0; k < NLANE; k++) begin
			s1_d.diff[k] = (nb[k] >= ctr) ? (nb[k] - ctr) : (ctr - nb[k]);
			s1_d.keep[k] = (nb[k] != 16'd0) && (s1_d.diff[k] <= thr_q);
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			p_s1 <= s1_d;
		end
	end

	// Stage 2: denominators and right-hand side (one multiply per lane)
	div_t p_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			p_s2.idx     <= p_s1.idx;
			p_s2.wr      <= p_s1.wr;
			p_s2.live    <= p_s1.live;
			p_s2.alpha_c <= p_s1.alpha_c;
			p_s2.rhs     <= {23'(p_s1.ci * p_s1.alpha_c), 1'b0};
			p_s2.keep    <= p_s1.keep;
			p_s2.rem     <= {NLANE{NUMER}};
			p_s2.q       <= '0;
			for (int k = 0; k < NLANE; k++) begin
				p_s2.den[k] <= DEN_ONE + DEN_W'(beta_q * p_s1.diff[k]);
			end
		end
	end

	// Stage 3: restoring division, one quotient bit per stage, high bit first
	div_t div_s3 [DIV_STEPS];

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		div_t               din, dout;
		logic [TRIAL_W-1:0] trial [NLANE];

		assign din = (j == 0) ? p_s2 : div_s3[(j == 0) ? 0 : j - 1];

		always_comb begin
			dout = din;
			for (int k = 0; k < NLANE; k++) begin
				trial[k] = TRIAL_W'(din.den[k]) << (DIV_STEPS - 1 - j);
				if (TRIAL_W'(din.rem[k]) >= trial[k]) begin
					dout.rem[k] = din.rem[k] - trial[k][DEN_W-1:0];
					dout.q[k][DIV_STEPS-1-j] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[j+2]) begin
				div_s3[j] <= dout;
			end
		end
	end

	// Stage 4: weights, diagonal sum and off-diagonal coefficients
	div_t                  dlast;
	logic [DIV_STEPS-1:0]  w [NLANE];
	logic [18:0]           neg [NLANE];
	out_item_t             row_d, out_s4;

	always_comb begin
		dlast = div_s3[DIV_STEPS-1];
		for (int k = 0; k < NLANE; k++) begin
			w[k]   = (dlast.keep[k] && dlast.live) ? dlast.q[k] : '0;
			neg[k] = 19'd0 - {w[k], 2'b00};
		end
		row_d.matrix_row  = dlast.idx;
		row_d.row_written = dlast.wr;
		row_d.diag_coeff  = dlast.live ?
			(25'({dlast.alpha_c, 9'd0}) + 25'({w[0], 2'b00}) + 25'({w[1], 2'b00})
			 + 25'({w[2], 2'b00}) + 25'({w[3], 2'b00})) : 25'd0;
		row_d.coeff_below = neg[0];
		row_d.coeff_above = neg[1];
		row_d.coeff_left  = neg[2];
		row_d.coeff_right = neg[3];
		row_d.rhs_value   = dlast.live ? dlast.rhs : 24'd0;
	end

	always_ff @(posedge clk) begin
		if (en[NSTAGE-1]) begin
			out_s4 <= row_d;
		end
	end

	assign row.valid = vld[NSTAGE-1];
	assign row.data  = out_s4;

	// Checks
	`ASSERT_IMPL(a_border_zero, row.valid && !row.data.row_written,
		row.data.diag_coeff == 25'd0 && row.data.rhs_value == 24'd0)
	`ASSERT_IMPL(a_rhs_even, row.valid, !row.data.rhs_value[0])
	`ASSERT_IMPL(a_weight_bound, vld[NSTAGE-2],
		dlast.q[0] <= 17'd65536 && dlast.q[1] <= 17'd65536 &&
		dlast.q[2] <= 17'd65536 && dlast.q[3] <= 17'd65536)
	`ASSERT_NEXT(a_stage_advance, vld[0] && en[1], vld[1])

endmodule
